[hdl/cta_pkg.sv]
// Shared types and constants for the compositing tier admission block.
// Used by every module in hdl/.
`default_nettype none

package cta_pkg;

	localparam int CTA_QUEUE_DEPTH = 2;

	localparam int CNT_W  = 16;
	localparam int SUM_W  = 48;
	localparam int PX_W   = 30;
	localparam int BY_W   = 38;
	localparam int IDX_W  = 3;
	localparam int BE_W   = 3;

	typedef enum logic [1:0] {
		TIER_DIRECT = 2'd0,
		TIER_BRUSH  = 2'd1,
		TIER_LAYER  = 2'd2,
		TIER_TARGET = 2'd3
	} cta_tier_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_EXTENT  = 2'd1,
		ERR_BACKEND = 2'd2,
		ERR_BUDGET  = 2'd3
	} cta_err_t;

	typedef enum logic [IDX_W-1:0] {
		REG_BACKEND      = 3'd0,
		REG_MAX_LAYERS   = 3'd1,
		REG_MAX_SURFACES = 3'd2,
		REG_MAX_PIXELS   = 3'd3,
		REG_MAX_BYTES    = 3'd4
	} cta_reg_t;

	typedef struct packed {
		logic [CNT_W-1:0] max_layers;
		logic [CNT_W-1:0] max_surfaces;
		logic [SUM_W-1:0] max_pixels;
		logic [SUM_W-1:0] max_bytes;
	} cta_budget_t;

	typedef struct packed {
		logic            first;
		logic            last;
		cta_tier_t       tier;
		cta_err_t        pre_err;
		logic [PX_W-1:0] px;
		logic [BY_W-1:0] by;
	} cta_entry_t;

	typedef struct packed {
		cta_err_t  first_error;
		logic      plan_ok;
		cta_err_t  error_code;
		logic      accepted;
		cta_tier_t tier;
	} cta_result_t;

endpackage

`default_nettype wire

[hdl/cta_front.sv]
// Front end: classifies a request into a tier, runs backend and extent checks,
// forms pixel and byte counts. Depends on cta_pkg.
`default_nettype none

module cta_front
	import cta_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [BE_W-1:0]  backend_available,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             first_of_plan,
	input  wire logic [3:0]       requirement_flags,
	input  wire logic [15:0]      extent_x,
	input  wire logic [15:0]      extent_y,
	input  wire logic [7:0]       bytes_per_pixel,
	input  wire logic             last_of_plan,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output cta_entry_t            out_entry
);

	cta_tier_t       tier_c;
	cta_err_t        err_c;
	logic            be_ok_c;
	logic            bad_extent_c;
	logic [PX_W-1:0] px_c;

	logic            valid_s1;
	logic            first_s1;
	logic            last_s1;
	cta_tier_t       tier_s1;
	cta_err_t        err_s1;
	logic [PX_W-1:0] px_s1;
	logic [7:0]      bpp_s1;

	always_comb begin
		if (|requirement_flags[1:0]) begin
			tier_c = TIER_TARGET;
		end else if (requirement_flags[2]) begin
			tier_c = TIER_LAYER;
		end else if (requirement_flags[3]) begin
			tier_c = TIER_BRUSH;
		end else begin
			tier_c = TIER_DIRECT;
		end
	end

	always_comb begin
		unique case (tier_c)
			TIER_BRUSH:  be_ok_c = backend_available[0];
			TIER_LAYER:  be_ok_c = backend_available[1];
			TIER_TARGET: be_ok_c = backend_available[2];
			default:     be_ok_c = 1'b1;
		endcase
	end

	assign bad_extent_c = extent_x[15] || (extent_x == 16'd0) ||
	                      extent_y[15] || (extent_y == 16'd0) ||
	                      (bytes_per_pixel == 8'd0);

	always_comb begin
		if (!be_ok_c) begin
			err_c = ERR_BACKEND;
		end else if ((tier_c == TIER_LAYER || tier_c == TIER_TARGET) && bad_extent_c) begin
			err_c = ERR_EXTENT;
		end else begin
			err_c = ERR_NONE;
		end
	end

	assign px_c = PX_W'(extent_x[14:0]) * PX_W'(extent_y[14:0]);

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			first_s1 <= first_of_plan;
			last_s1  <= last_of_plan;
			tier_s1  <= tier_c;
			err_s1   <= err_c;
			px_s1    <= px_c;
			bpp_s1   <= bytes_per_pixel;
		end
	end

	always_comb begin
		out_entry.first   = first_s1;
		out_entry.last    = last_s1;
		out_entry.tier    = tier_s1;
		out_entry.pre_err = err_s1;
		out_entry.px      = px_s1;
		out_entry.by      = BY_W'(px_s1) * BY_W'(bpp_s1);
	end

endmodule

`default_nettype wire

[hdl/cta_queue.sv]
// Short queue between the front end and the budget stage.
// Depends on cta_pkg for the entry type.
`default_nettype none

module cta_queue
	import cta_pkg::*;
#(
	parameter int DEPTH = CTA_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push_valid,
	output logic            push_ready,
	input  wire cta_entry_t push_data,
	output logic            pop_valid,
	input  wire logic       pop_ready,
	output cta_entry_t      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	cta_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != CNT_QW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[hdl/cta_back.sv]
// Back end: checks budgets against reserved usage, commits usage and plan
// status, holds the result register. Depends on cta_pkg.
`default_nettype none

module cta_back
	import cta_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cta_budget_t budget,
	input  wire logic        pop_valid,
	output logic             pop_ready,
	input  wire cta_entry_t  pop_data,
	output logic             res_valid,
	input  wire logic        res_ready,
	output cta_result_t      res_data,
	output logic             res_last
);

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EVAL = 2'b10
	} cta_back_state_t;

	cta_back_state_t  state_q;
	cta_entry_t       ent_q;
	logic [SUM_W-1:0] hp_q;
	logic [SUM_W-1:0] hb_q;
	logic             layer_ok_q;
	logic             surf_ok_q;

	logic [CNT_W-1:0] res_l_q;
	logic [CNT_W-1:0] res_s_q;
	logic [SUM_W-1:0] res_p_q;
	logic [SUM_W-1:0] res_b_q;
	cta_err_t         fes_q;

	logic             out_valid_q;
	cta_result_t      out_q;
	logic             out_last_q;

	logic [CNT_W-1:0] eff_l;
	logic [CNT_W-1:0] eff_s;
	logic [SUM_W-1:0] eff_p;
	logic [SUM_W-1:0] eff_b;
	logic [SUM_W:0]   diff_p;
	logic [SUM_W:0]   diff_b;

	logic             load;
	logic             finish;
	logic             big_tier;
	logic             over;
	cta_err_t         err_c;
	cta_err_t         fes_next;

	assign pop_ready = (state_q == ST_LOAD);
	assign load      = pop_ready && pop_valid;
	assign finish    = (state_q == ST_EVAL) && (!out_valid_q || res_ready);

	assign eff_l  = pop_data.first ? '0 : res_l_q;
	assign eff_s  = pop_data.first ? '0 : res_s_q;
	assign eff_p  = pop_data.first ? '0 : res_p_q;
	assign eff_b  = pop_data.first ? '0 : res_b_q;
	assign diff_p = {1'b0, budget.max_pixels} - {1'b0, eff_p};
	assign diff_b = {1'b0, budget.max_bytes} - {1'b0, eff_b};

	assign big_tier = (ent_q.tier == TIER_LAYER) || (ent_q.tier == TIER_TARGET);
	assign over     = !layer_ok_q || !surf_ok_q ||
	                  (SUM_W'(ent_q.px) > hp_q) ||
	                  (SUM_W'(ent_q.by) > hb_q);

	always_comb begin
		if (ent_q.pre_err != ERR_NONE) begin
			err_c = ent_q.pre_err;
		end else if (big_tier && over) begin
			err_c = ERR_BUDGET;
		end else begin
			err_c = ERR_NONE;
		end
	end

	assign fes_next = (fes_q == ERR_NONE) ? err_c : fes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			res_l_q     <= '0;
			res_s_q     <= '0;
			res_p_q     <= '0;
			res_b_q     <= '0;
			fes_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (load) begin
						if (pop_data.first) begin
							res_l_q <= '0;
							res_s_q <= '0;
							res_p_q <= '0;
							res_b_q <= '0;
							fes_q   <= ERR_NONE;
						end
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (finish) begin
						if (big_tier && err_c == ERR_NONE) begin
							res_l_q <= res_l_q + CNT_W'(ent_q.tier == TIER_LAYER);
							res_s_q <= res_s_q + CNT_W'(ent_q.tier == TIER_TARGET);
							res_p_q <= res_p_q + SUM_W'(ent_q.px);
							res_b_q <= res_b_q + SUM_W'(ent_q.by);
						end
						fes_q   <= fes_next;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q      <= pop_data;
			hp_q       <= diff_p[SUM_W] ? '0 : diff_p[SUM_W-1:0];
			hb_q       <= diff_b[SUM_W] ? '0 : diff_b[SUM_W-1:0];
			layer_ok_q <= (pop_data.tier == TIER_LAYER) ? (eff_l < budget.max_layers) :
			              (eff_l <= budget.max_layers);
			surf_ok_q  <= (pop_data.tier == TIER_TARGET) ? (eff_s < budget.max_surfaces) :
			              (eff_s <= budget.max_surfaces);
		end
		if (finish) begin
			out_q.tier        <= ent_q.tier;
			out_q.accepted    <= (err_c == ERR_NONE);
			out_q.error_code  <= err_c;
			out_q.plan_ok     <= (fes_next == ERR_NONE);
			out_q.first_error <= fes_next;
			out_last_q        <= ent_q.last;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;
	assign res_last  = out_last_q;

endmodule

`default_nettype wire

[hdl/compositing_tier_admission.sv]
// Top level of the compositing tier admission block: configuration registers,
// front end, queue and budget back end. Depends on cta_pkg and all hdl/ modules.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata, s_tuser, s_tlast (one request)
// m_*       out  m_tvalid/m_tready  m_tdata, m_tlast (one result per request)
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (register write)
//
// The front end takes a request every cycle until the queue is full.
// The back end handles one request at a time: it loads the headroom, then
// compares and commits reserved usage before it takes the next request.
// Each request is registered in the front end, the queue and the back end in turn.
// Reset clears configuration, reserved usage and plan status.
// A stalled m_tready holds the result; the queue then fills and s_tready drops.
`default_nettype none

module compositing_tier_admission
	import cta_pkg::*;
#(
	parameter int QUEUE_DEPTH = CTA_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// [3:0] requirement_flags, [19:4] extent_x, [35:20] extent_y,
	// [43:36] bytes_per_pixel, [47:44] zero
	input  wire logic [47:0]      s_tdata,
	// [0] first_of_plan
	input  wire logic             s_tuser,
	input  wire logic             s_tlast,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// [1:0] tier, [2] accepted, [4:3] error_code, [5] plan_ok, [7:6] first_error
	output logic [7:0]            m_tdata,
	output logic                  m_tlast,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [SUM_W-1:0] cfg_data
);

	logic [BE_W-1:0] backend_q;
	cta_budget_t     budget_q;

	logic            fr_valid;
	logic            fr_ready;
	cta_entry_t      fr_entry;
	logic            q_valid;
	logic            q_ready;
	cta_entry_t      q_entry;
	cta_result_t     res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backend_q <= '0;
			budget_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BACKEND:      backend_q             <= cfg_data[BE_W-1:0];
				REG_MAX_LAYERS:   budget_q.max_layers   <= cfg_data[CNT_W-1:0];
				REG_MAX_SURFACES: budget_q.max_surfaces <= cfg_data[CNT_W-1:0];
				REG_MAX_PIXELS:   budget_q.max_pixels   <= cfg_data;
				REG_MAX_BYTES:    budget_q.max_bytes    <= cfg_data;
				default: ;
			endcase
		end
	end

	cta_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.backend_available (backend_q),
		.in_valid          (s_tvalid),
		.in_ready          (s_tready),
		.first_of_plan     (s_tuser),
		.requirement_flags (s_tdata[3:0]),
		.extent_x          (s_tdata[19:4]),
		.extent_y          (s_tdata[35:20]),
		.bytes_per_pixel   (s_tdata[43:36]),
		.last_of_plan      (s_tlast),
		.out_valid         (fr_valid),
		.out_ready         (fr_ready),
		.out_entry         (fr_entry)
	);

	cta_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_entry),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_entry)
	);

	cta_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.budget    (budget_q),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_data  (q_entry),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (res),
		.res_last  (m_tlast)
	);

	assign m_tdata = res;

	a_accept_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.accepted == (res.error_code == ERR_NONE)))
		else $error("accepted flag disagrees with error code");

	a_plan_ok_first_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.plan_ok == (res.first_error == ERR_NONE)))
		else $error("plan status disagrees with first error");

	a_reject_sets_first: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res.accepted) |-> (res.first_error != ERR_NONE))
		else $error("rejection left first error clear");

	a_direct_always_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.tier == TIER_DIRECT) |-> res.accepted)
		else $error("direct paint request rejected");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for compositing_tier_admission: directed and random request
// streams against an in-bench admission predictor, with random stalls on both streams.
// Depends on cta_pkg and the RTL in hdl/.
`timescale 1ns / 1ps

module tb_top
	import cta_pkg::*;
();

	localparam logic [SUM_W-1:0] ALL_ONES48 = '1;

	typedef struct packed {
		logic        done;
		cta_result_t res;
	} plan_verdict_t;

	class admission_scoreboard;
		logic [BE_W-1:0] backend;
		longint unsigned lim_layers, lim_surfaces, lim_pixels, lim_bytes;
		longint unsigned used_layers, used_surfaces, used_pixels, used_bytes;
		cta_err_t        first_err;
		plan_verdict_t   verdicts[$];
		int              errors;

		function new();
			backend = '0;
			lim_layers = 0;
			lim_surfaces = 0;
			lim_pixels = 0;
			lim_bytes = 0;
			clear_plan();
			errors = 0;
		endfunction

		function void clear_plan();
			used_layers = 0;
			used_surfaces = 0;
			used_pixels = 0;
			used_bytes = 0;
			first_err = ERR_NONE;
		endfunction

		static function longint unsigned sat_sum(longint unsigned a, longint unsigned b,
				longint unsigned lim);
			if (a >= lim || b > lim - a)
				return lim;
			return a + b;
		endfunction

		static function longint unsigned room(longint unsigned used, longint unsigned lim);
			return used >= lim ? 0 : lim - used;
		endfunction

		function void write_register(logic [IDX_W-1:0] idx, logic [SUM_W-1:0] data);
			case (idx)
				REG_BACKEND: backend = data[BE_W-1:0];
				REG_MAX_LAYERS: lim_layers = data[CNT_W-1:0];
				REG_MAX_SURFACES: lim_surfaces = data[CNT_W-1:0];
				REG_MAX_PIXELS: lim_pixels = data;
				REG_MAX_BYTES: lim_bytes = data;
				default: ;
			endcase
		endfunction

		function void admit_request(bit first, logic [3:0] flags, logic signed [15:0] ex,
				logic signed [15:0] ey, logic [7:0] bpp, bit last);
			cta_tier_t       tier;
			cta_err_t        err;
			longint unsigned px, by, add_l, add_s;
			plan_verdict_t   v;
			if (first)
				clear_plan();
			if (flags[1:0] != 2'b00)
				tier = TIER_TARGET;
			else if (flags[2])
				tier = TIER_LAYER;
			else if (flags[3])
				tier = TIER_BRUSH;
			else
				tier = TIER_DIRECT;
			err = ERR_NONE;
			if (tier != TIER_DIRECT && !backend[int'(tier) - 1])
				err = ERR_BACKEND;
			if (err == ERR_NONE && (tier == TIER_LAYER || tier == TIER_TARGET)) begin
				if (ex <= 0 || ey <= 0 || bpp == 0) begin
					err = ERR_EXTENT;
				end else begin
					px = longint'(ex) * longint'(ey);
					by = px * bpp;
					add_l = tier == TIER_LAYER ? 1 : 0;
					add_s = tier == TIER_TARGET ? 1 : 0;
					if (used_layers + add_l > lim_layers || used_surfaces + add_s > lim_surfaces ||
							px > room(used_pixels, lim_pixels) ||
							by > room(used_bytes, lim_bytes)) begin
						err = ERR_BUDGET;
					end else begin
						used_layers = sat_sum(used_layers, add_l, 64'hFFFF);
						used_surfaces = sat_sum(used_surfaces, add_s, 64'hFFFF);
						used_pixels = sat_sum(used_pixels, px, ALL_ONES48);
						used_bytes = sat_sum(used_bytes, by, ALL_ONES48);
					end
				end
			end
			if (err != ERR_NONE && first_err == ERR_NONE)
				first_err = err;
			v.done = last;
			v.res.tier = tier;
			v.res.accepted = err == ERR_NONE;
			v.res.error_code = err;
			v.res.plan_ok = first_err == ERR_NONE;
			v.res.first_error = first_err;
			verdicts.push_back(v);
		endfunction

		function void compare(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [7:0] data, logic done);
			cta_result_t   got;
			plan_verdict_t want;
			got = data;
			if (verdicts.size() == 0) begin
				$display("%0t unexpected result: expected none actual %h", $time, data);
				errors++;
				return;
			end
			want = verdicts.pop_front();
			compare("tier", 8'(want.res.tier), 8'(got.tier));
			compare("accepted", 8'(want.res.accepted), 8'(got.accepted));
			compare("error_code", 8'(want.res.error_code), 8'(got.error_code));
			compare("plan_ok", 8'(want.res.plan_ok), 8'(got.plan_ok));
			compare("first_error", 8'(want.res.first_error), 8'(got.first_error));
			compare("plan_done", 8'(want.done), 8'(done));
		endfunction

		function int pending();
			return verdicts.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [47:0]      s_tdata;
	logic             s_tuser;
	logic             s_tlast;
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;
	logic             m_tlast;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [SUM_W-1:0] cfg_data;

	int src_idle_pct = 25;
	int snk_idle_pct = 52;

	admission_scoreboard sb = new();

	compositing_tier_admission u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			m_tready <= $urandom_range(99) >= snk_idle_pct;
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tlast);
		end
	end

	task automatic send_request(bit first, logic [3:0] flags, logic [15:0] ex, logic [15:0] ey,
			logic [7:0] bpp, bit last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, bpp, ey, ex, flags};
		s_tuser <= first;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.admit_request(first, flags, ex, ey, bpp, last);
	endtask

	task automatic write_register(logic [IDX_W-1:0] idx, logic [SUM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, data);
	endtask

	// hold the sender until every outstanding result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [SUM_W-1:0] with_noise(logic [SUM_W-1:0] v, int w);
		logic [SUM_W-1:0] r;
		r = SUM_W'({$urandom, $urandom});
		return (r & ~((48'd1 << w) - 48'd1)) | v;
	endfunction

	function automatic logic [15:0] pick_extent();
		case ($urandom_range(15))
			0: return 16'($urandom);
			1: return 16'(-int'($urandom_range(32768)));
			2: return 16'($urandom_range(32767));
			default: return 16'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic logic [3:0] pick_flags();
		if ($urandom_range(3) == 0)
			return {1'($urandom_range(1)), 3'b100};
		return 4'($urandom_range(15));
	endfunction

	task automatic apply_setting(int mode);
		logic [BE_W-1:0]  be;
		logic [CNT_W-1:0] nl, ns;
		logic [SUM_W-1:0] np, nb;
		case (mode)
			0: begin
				be = '1; nl = '1; ns = '1; np = '1; nb = '1;
			end
			1: begin
				be = '1; nl = '0; ns = '0; np = '0; nb = '0;
			end
			2: begin
				be = BE_W'($urandom_range(7));
				nl = CNT_W'($urandom_range(8));
				ns = CNT_W'($urandom_range(8));
				np = SUM_W'($urandom_range(1 << 16));
				nb = SUM_W'($urandom_range(1 << 20));
			end
			default: begin
				be = BE_W'($urandom);
				nl = CNT_W'($urandom);
				ns = CNT_W'($urandom);
				np = SUM_W'({$urandom, $urandom});
				nb = SUM_W'({$urandom, $urandom});
			end
		endcase
		write_register(REG_BACKEND, with_noise(SUM_W'(be), BE_W));
		write_register(REG_MAX_LAYERS, with_noise(SUM_W'(nl), CNT_W));
		write_register(REG_MAX_SURFACES, with_noise(SUM_W'(ns), CNT_W));
		write_register(REG_MAX_PIXELS, np);
		write_register(REG_MAX_BYTES, nb);
		write_register(IDX_W'(int'(REG_MAX_BYTES) + $urandom_range(1, 3)),
			SUM_W'({$urandom, $urandom}));
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed plans, some loose items; a segment may continue the previous plan
	task automatic random_segment(int n_items);
		int left;
		int plan_len;
		bit carry;
		left = n_items;
		carry = 1'($urandom_range(1));
		while (left > 0) begin
			if ($urandom_range(9) == 0) begin
				send_request(1'($urandom_range(1)), 4'($urandom_range(15)), 16'($urandom),
					16'($urandom), 8'($urandom), 1'($urandom_range(1)));
				left--;
			end else begin
				plan_len = $urandom_range(1, 8);
				for (int i = 0; i < plan_len && left > 0; i++) begin
					send_request(i == 0 && !carry, pick_flags(), pick_extent(), pick_extent(),
						$urandom_range(15) == 0 ? 8'd0 : 8'($urandom),
						i == plan_len - 1 || left == 1);
					left--;
				end
			end
			carry = 1'b0;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no backend present after reset
		send_request(1'b1, 4'b0000, 16'd1, 16'd1, 8'd1, 1'b0);
		send_request(1'b0, 4'b1000, 16'd1, 16'd1, 8'd1, 1'b0);
		send_request(1'b0, 4'b0100, 16'd1, 16'd1, 8'd1, 1'b0);
		send_request(1'b0, 4'b0001, 16'd1, 16'd1, 8'd1, 1'b1);
		drain();

		write_register(REG_BACKEND, 48'd7);
		write_register(REG_MAX_LAYERS, 48'd2);
		write_register(REG_MAX_SURFACES, 48'd2);
		write_register(REG_MAX_PIXELS, ALL_ONES48);
		write_register(REG_MAX_BYTES, ALL_ONES48);
		for (int i = int'(REG_MAX_BYTES) + 1; i < (1 << IDX_W); i++)
			write_register(IDX_W'(i), ALL_ONES48);
		cfg_valid <= 1'b0;

		// every flag combination; surfaces run out of budget
		for (int f = 0; f < 16; f++)
			send_request(f == 0, 4'(f), 16'd10, 16'd10, 8'd4, f == 15);
		send_request(1'b1, 4'b0100, 16'h7FFF, 16'h7FFF, 8'hFF, 1'b0);
		send_request(1'b0, 4'b0010, 16'h8000, 16'd5, 8'd1, 1'b0);
		send_request(1'b0, 4'b0010, 16'd0, 16'd5, 8'd1, 1'b0);
		send_request(1'b0, 4'b0001, 16'd5, 16'hFFFF, 8'd1, 1'b0);
		send_request(1'b0, 4'b0100, 16'd5, 16'd5, 8'd0, 1'b0);
		send_request(1'b0, 4'b1000, 16'h8000, 16'h8000, 8'd0, 1'b1);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 25;
					snk_idle_pct = 52;
				end
				1: begin
					src_idle_pct = 52;
					snk_idle_pct = 25;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				apply_setting((phase + seg) % 4);
				random_segment(100);
				drain();
			end
		end

		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0t %0d results never arrived", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
